>>> hw/rtl/dilp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dilp_pkg: shared types and constants of the decimal list parser
// byte classes, character codes, status codes and queue sizes
// ----------------------------------------------------------------------------
package dilp_pkg;

   // value range is [-2^(VALUE_BITS-1), 2^(VALUE_BITS-1)-1]
   localparam int VALUE_BITS = 32;
   localparam int MAG_W      = VALUE_BITS;
   localparam int NUMBER_W   = 32;

   typedef logic [MAG_W-1:0]    mag_type;
   typedef logic [NUMBER_W-1:0] number_type;

   localparam mag_type     MAG_LIMIT   = {1'b1, {(MAG_W-1){1'b0}}};
   localparam logic [63:0] LIMIT_WIDE  = 64'd1 << (VALUE_BITS - 1);
   localparam logic [63:0] NLIMIT_WIDE = ~LIMIT_WIDE + 64'd1;
   localparam number_type  VAL_POS_SAT = LIMIT_WIDE[NUMBER_W-1:0];
   localparam number_type  VAL_NEG_SAT = NLIMIT_WIDE[NUMBER_W-1:0];

   // character codes
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_BYTE  = 2'd1;
   localparam logic [1:0] STATUS_MIXED_SEP = 2'd2;
   localparam logic [1:0] STATUS_RANGE     = 2'd3;

   typedef enum logic [3:0] {
      KIND_SEP   = 4'b0001,
      KIND_DIGIT = 4'b0010,
      KIND_SIGN  = 4'b0100,
      KIND_BAD   = 4'b1000
   } kind_type;

   // one classified byte
   typedef struct packed {
      kind_type   kind;
      logic [7:0] text_byte;
      logic [3:0] digit;
      logic       minus;
      logic       arg_end;
   } cmd_type;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

endpackage : dilp_pkg
`default_nettype wire

>>> hw/rtl/decimal_int_list_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_int_list_parser_core: streaming parser for lists of decimal integers
// turns argument text into signed 32-bit values, one per token, or one error
// ----------------------------------------------------------------------------
//
//  channel   ports                              moves
//  --------  ---------------------------------  ------------------------------
//  request   push, full, req_text_byte,         one text byte per transaction
//            req_arg_end
//  response  empty, pop, rsp_number,            one value or error status per
//            rsp_status                         transaction
//
//  one byte per cycle sustained while the result queue has room; the parser
//  applies one byte per cycle (one multiply-by-ten add and limit compare)
//  in the parser stage; a byte's result passes the front register and both queues
//  synchronous active-high reset clears all control state, no clearing pass
//  a four-entry command queue and a two-entry result queue let either side
//  stall on its own; after an error the block drops bytes until reset
//
module decimal_int_list_parser_core (
   input  wire logic          clock,
   input  wire logic          reset,
   // request side
   input  wire logic          push,
   output logic               full,
   input  wire logic [7:0]    req_text_byte,
   input  wire logic          req_arg_end,
   // response side
   output logic               empty,
   input  wire logic          pop,
   output logic signed [31:0] rsp_number,
   output logic [1:0]         rsp_status
);
   import dilp_pkg::*;

   // front stage to command queue
   logic    front_valid;
   cmd_type front_cmd;
   logic    front_take;

   // command queue to parser
   logic    queue_valid;
   cmd_type queue_cmd;
   logic    queue_take;

   // front stage: classify each byte into separator, digit, sign or invalid
   dilp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_text_byte (req_text_byte),
      .req_arg_end   (req_arg_end),
      .out_valid     (front_valid),
      .out_cmd       (front_cmd),
      .out_take      (front_take)
   );

   // decoupling queue between classification and parsing
   dilp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_cmd   (front_cmd),
      .wr_ready (front_take),
      .rd_valid (queue_valid),
      .rd_cmd   (queue_cmd),
      .rd_take  (queue_take)
   );

   // back end: token state, range check, error halt and result queue
   dilp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd        (queue_cmd),
      .cmd_take   (queue_take),
      .empty      (empty),
      .pop        (pop),
      .rsp_number (rsp_number),
      .rsp_status (rsp_status)
   );

endmodule : decimal_int_list_parser_core
`default_nettype wire

>>> hw/rtl/dilp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dilp_front: input stage
// takes one byte per cycle unless full, classifies it and holds it for the command queue
// ----------------------------------------------------------------------------
module dilp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [7:0]       req_text_byte,
   input  wire logic             req_arg_end,
   output logic                  out_valid,
   output dilp_pkg::cmd_type     out_cmd,
   input  wire logic             out_take
);
   import dilp_pkg::*;

   logic       valid_ff, valid_in;
   cmd_type    cmd_ff, cmd_in;
   logic       accept;
   logic [7:0] digit_diff;
   logic       is_sep;
   logic       is_digit;

   assign full       = valid_ff && !out_take;
   assign accept     = push && !full;
   assign digit_diff = req_text_byte - CHAR_ZERO;

   assign is_sep = (req_text_byte == CHAR_COMMA) || (req_text_byte == CHAR_SEMI) ||
                   (req_text_byte == CHAR_SPACE) || (req_text_byte == CHAR_TAB) ||
                   (req_text_byte == CHAR_LF)    || (req_text_byte == CHAR_VT) ||
                   (req_text_byte == CHAR_FF)    || (req_text_byte == CHAR_CR);
   assign is_digit = (req_text_byte >= CHAR_ZERO) && (req_text_byte <= CHAR_NINE);

   always_comb begin
      cmd_in.text_byte = req_text_byte;
      cmd_in.arg_end   = req_arg_end;
      cmd_in.digit     = digit_diff[3:0];
      cmd_in.minus     = (req_text_byte == CHAR_MINUS);
      if (is_sep) begin
         cmd_in.kind = KIND_SEP;
      end else if (is_digit) begin
         cmd_in.kind = KIND_DIGIT;
      end else if ((req_text_byte == CHAR_PLUS) || (req_text_byte == CHAR_MINUS)) begin
         cmd_in.kind = KIND_SIGN;
      end else begin
         cmd_in.kind = KIND_BAD;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (out_take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_cmd   = cmd_ff;

endmodule : dilp_front
`default_nettype wire

>>> hw/rtl/dilp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dilp_queue: command queue
// short first-in first-out buffer between the input stage and the parser
// ----------------------------------------------------------------------------
module dilp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   input  wire dilp_pkg::cmd_type wr_cmd,
   output logic                  wr_ready,
   output logic                  rd_valid,
   output dilp_pkg::cmd_type     rd_cmd,
   input  wire logic             rd_take
);
   import dilp_pkg::*;

   cmd_type              mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_wr;
   logic                 do_rd;

   assign wr_ready = (count_ff != CMD_CNT_W'(CMD_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_take && rd_valid;
   assign rd_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule : dilp_queue
`default_nettype wire

>>> hw/rtl/dilp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dilp_back: token parser and result queue
// runs the token state per byte and queues finished values and errors
// ----------------------------------------------------------------------------
module dilp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire dilp_pkg::cmd_type cmd,
   output logic                   cmd_take,
   output logic                   empty,
   input  wire logic              pop,
   output logic signed [31:0]     rsp_number,
   output logic [1:0]             rsp_status
);
   import dilp_pkg::*;

   // parser state
   logic       halted_ff, halted_in;
   logic       sep_known_ff, sep_known_in;
   logic [7:0] sep_char_ff, sep_char_in;
   logic       in_token_ff, in_token_in;
   logic       negative_ff, negative_in;
   logic       stopped_ff, stopped_in;
   mag_type    mag_ff, mag_in;
   logic       over_ff, over_in;
   number_type val_ff, val_in;

   // result queue, two entries
   number_type rq_number_ff [2];
   logic [1:0] rq_status_ff [2];
   logic       rq_wr_ptr_ff, rq_rd_ptr_ff;
   logic [1:0] rq_count_ff, rq_count_in;
   logic       rq_room;
   logic       rq_pop;

   logic           emit;
   number_type     res_number;
   logic [1:0]     res_status;
   logic [MAG_W+3:0] prod;
   logic           add_over;
   mag_type        add_mag;
   number_type     val_x10;
   number_type     add_val;
   number_type     digit_ext;
   logic           do_finish;
   logic           err;
   logic [1:0]     err_code;

   assign rq_pop   = pop && !empty;
   assign empty    = (rq_count_ff == 2'd0);
   assign rq_room  = (rq_count_ff != 2'd2) || rq_pop;
   assign cmd_take = cmd_valid && rq_room;

   // accumulate one decimal digit: mag*10 + d with saturation at the limit
   assign prod      = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0}
                    + {{MAG_W{1'b0}}, cmd.digit};
   assign add_over  = prod > {4'b0000, MAG_LIMIT};
   assign add_mag   = add_over ? MAG_LIMIT : prod[MAG_W-1:0];
   assign digit_ext = {{(NUMBER_W-4){1'b0}}, cmd.digit};
   assign val_x10   = {val_ff[NUMBER_W-4:0], 3'b000} + {val_ff[NUMBER_W-2:0], 1'b0};

   always_comb begin
      if (add_over) begin
         add_val = negative_ff ? VAL_NEG_SAT : VAL_POS_SAT;
      end else if (negative_ff) begin
         add_val = val_x10 - digit_ext;
      end else begin
         add_val = val_x10 + digit_ext;
      end
   end

   always_comb begin
      halted_in    = halted_ff;
      sep_known_in = sep_known_ff;
      sep_char_in  = sep_char_ff;
      in_token_in  = in_token_ff;
      negative_in  = negative_ff;
      stopped_in   = stopped_ff;
      mag_in       = mag_ff;
      over_in      = over_ff;
      val_in       = val_ff;
      emit         = 1'b0;
      res_number   = '0;
      res_status   = STATUS_OK;
      do_finish    = 1'b0;
      err          = 1'b0;
      err_code     = STATUS_BAD_BYTE;

      if (cmd_take && !halted_ff) begin
         case (cmd.kind)
            KIND_SEP: begin
               if (sep_known_ff && (sep_char_ff != cmd.text_byte)) begin
                  err      = 1'b1;
                  err_code = STATUS_MIXED_SEP;
               end else begin
                  sep_known_in = 1'b1;
                  sep_char_in  = cmd.text_byte;
                  do_finish    = in_token_ff;
               end
            end
            KIND_DIGIT, KIND_SIGN: begin
               if (!in_token_ff) begin
                  in_token_in = 1'b1;
                  negative_in = cmd.minus;
                  stopped_in  = 1'b0;
                  over_in     = 1'b0;
                  if (cmd.kind == KIND_DIGIT) begin
                     mag_in = {{(MAG_W-4){1'b0}}, cmd.digit};
                     val_in = digit_ext;
                  end else begin
                     mag_in = '0;
                     val_in = '0;
                  end
               end else if (!stopped_ff) begin
                  if (cmd.kind == KIND_DIGIT) begin
                     mag_in  = add_mag;
                     val_in  = add_val;
                     over_in = over_ff || add_over;
                  end else begin
                     stopped_in = 1'b1;
                  end
               end
               do_finish = cmd.arg_end;
            end
            KIND_BAD: begin
               err      = 1'b1;
               err_code = STATUS_BAD_BYTE;
            end
            default: begin
               err      = 1'b1;
               err_code = STATUS_BAD_BYTE;
            end
         endcase

         // token end: range check, then emit value or range error
         if (do_finish && !err) begin
            if (over_in || (!negative_in && mag_in[MAG_W-1])) begin
               err      = 1'b1;
               err_code = STATUS_RANGE;
            end else begin
               emit        = 1'b1;
               res_number  = val_in;
               res_status  = STATUS_OK;
               in_token_in = 1'b0;
               negative_in = 1'b0;
               stopped_in  = 1'b0;
               mag_in      = '0;
               over_in     = 1'b0;
               val_in      = '0;
            end
         end

         if (err || cmd.arg_end) begin
            sep_known_in = 1'b0;
            sep_char_in  = '0;
            in_token_in  = 1'b0;
            negative_in  = 1'b0;
            stopped_in   = 1'b0;
            mag_in       = '0;
            over_in      = 1'b0;
            val_in       = '0;
         end

         if (err) begin
            emit       = 1'b1;
            res_number = '0;
            res_status = err_code;
            halted_in  = 1'b1;
         end
      end
   end

   always_comb begin
      rq_count_in = rq_count_ff;
      if (emit && !rq_pop) begin
         rq_count_in = rq_count_ff + 2'd1;
      end else if (rq_pop && !emit) begin
         rq_count_in = rq_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff    <= 1'b0;
         sep_known_ff <= 1'b0;
         sep_char_ff  <= '0;
         in_token_ff  <= 1'b0;
         negative_ff  <= 1'b0;
         stopped_ff   <= 1'b0;
         mag_ff       <= '0;
         over_ff      <= 1'b0;
         val_ff       <= '0;
         rq_wr_ptr_ff <= 1'b0;
         rq_rd_ptr_ff <= 1'b0;
         rq_count_ff  <= 2'd0;
      end else begin
         halted_ff    <= halted_in;
         sep_known_ff <= sep_known_in;
         sep_char_ff  <= sep_char_in;
         in_token_ff  <= in_token_in;
         negative_ff  <= negative_in;
         stopped_ff   <= stopped_in;
         mag_ff       <= mag_in;
         over_ff      <= over_in;
         val_ff       <= val_in;
         rq_wr_ptr_ff <= emit ? !rq_wr_ptr_ff : rq_wr_ptr_ff;
         rq_rd_ptr_ff <= rq_pop ? !rq_rd_ptr_ff : rq_rd_ptr_ff;
         rq_count_ff  <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rq_number_ff[rq_wr_ptr_ff] <= res_number;
         rq_status_ff[rq_wr_ptr_ff] <= res_status;
      end
   end

   assign rsp_number = rq_number_ff[rq_rd_ptr_ff];
   assign rsp_status = rq_status_ff[rq_rd_ptr_ff];

endmodule : dilp_back
`default_nettype wire

>>> verif/decimal_int_list_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_int_list_parser_core_tb: self-checking bench for the list parser
// streams argument text through the request queue and checks every value or
// error status against typed-in answers or a cycle-free parser model kept here
// ----------------------------------------------------------------------------
module decimal_int_list_parser_core_tb;
   import dilp_pkg::*;

   // which part of the directed stimulus a row belongs to; only one of the
   // error groups can run, since an error halts the block until reset
   typedef enum logic [1:0] {GRP_MAIN, GRP_BAD, GRP_MIX, GRP_RANGE} grp_type;

   // how a directed row is checked: by the model, or by a typed-in answer
   typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_RESULT} chk_type;

   typedef struct packed {
      number_type num;
      logic [1:0] status;
   } parse_out_type;

   typedef struct packed {
      grp_type    grp;
      logic [7:0] text;
      logic       is_last;
      chk_type    chk;
      number_type num;
      logic [1:0] status;
   } row_type;

   localparam int ROW_COUNT    = 40;
   localparam int RANDOM_ITEMS = 430;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               push          = 1'b0;
   logic               full;
   logic [7:0]         req_text_byte = 8'h00;
   logic               req_arg_end   = 1'b0;
   logic               empty;
   logic               pop           = 1'b0;
   logic signed [31:0] rsp_number;
   logic [1:0]         rsp_status;

   // values and statuses still owed by the block, oldest first
   parse_out_type pending_values[$];
   int            mismatch_count = 0;
   int            items_sent     = 0;

   // idle shaping: a burst flag gives stretches with no gaps on either side
   bit tx_burst = 1'b0;
   bit rx_burst = 1'b0;
   int rx_wait  = 0;

   // model state of the parser
   bit         prs_halted  = 1'b0;
   bit         prs_sep_set = 1'b0;
   logic [7:0] prs_sep     = 8'h00;
   bit         prs_in_tok  = 1'b0;
   bit         prs_neg     = 1'b0;
   bit         prs_stopped = 1'b0;
   mag_type    prs_mag     = '0;
   bit         prs_over    = 1'b0;

   // directed stimulus: extremes of the value range, sign-only token,
   // empty argument, then one group per error kind
   row_type stim_rows [0:ROW_COUNT-1] = '{
      // largest positive value, closed by the end of the argument
      '{GRP_MAIN, "2", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "1", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "4", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "7", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "4", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "8", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "3", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "6", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "4", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "7", 1'b1, CHK_RESULT, 32'h7FFF_FFFF, STATUS_OK},
      // most negative value
      '{GRP_MAIN, "-", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "2", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "1", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "4", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "7", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "4", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "8", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "3", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "6", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "4", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "8", 1'b1, CHK_RESULT, 32'h8000_0000, STATUS_OK},
      // sign then a non-digit: digits stop at once, value zero
      '{GRP_MAIN, "-", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MAIN, "+", 1'b1, CHK_RESULT, 32'h0, STATUS_OK},
      // argument holding only a separator gives nothing
      '{GRP_MAIN, CHAR_SPACE, 1'b1, CHK_NONE, 32'h0, STATUS_OK},
      // invalid byte drops the token in progress
      '{GRP_BAD, "7", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_BAD, 8'hFF, 1'b0, CHK_RESULT, 32'h0, STATUS_BAD_BYTE},
      // earlier token comes out before the mixed-separator error
      '{GRP_MIX, "1", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MIX, CHAR_COMMA, 1'b0, CHK_RESULT, 32'h1, STATUS_OK},
      '{GRP_MIX, "2", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_MIX, CHAR_SEMI, 1'b0, CHK_RESULT, 32'h0, STATUS_MIXED_SEP},
      // one past the largest positive value
      '{GRP_RANGE, "2", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_RANGE, "1", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_RANGE, "4", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_RANGE, "7", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_RANGE, "4", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_RANGE, "8", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_RANGE, "3", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_RANGE, "6", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_RANGE, "4", 1'b0, CHK_NONE, 32'h0, STATUS_OK},
      '{GRP_RANGE, "8", 1'b1, CHK_RESULT, 32'h0, STATUS_RANGE}
   };

   decimal_int_list_parser_core u_top (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_text_byte (req_text_byte),
      .req_arg_end   (req_arg_end),
      .empty         (empty),
      .pop           (pop),
      .rsp_number    (rsp_number),
      .rsp_status    (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // parser model
   // ---------------------------------------------------------------------

   function automatic bit is_sep(logic [7:0] b);
      return b == CHAR_COMMA || b == CHAR_SEMI || b == CHAR_SPACE || b == CHAR_TAB ||
             b == CHAR_LF || b == CHAR_VT || b == CHAR_FF || b == CHAR_CR;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic void drop_token();
      prs_in_tok  = 1'b0;
      prs_neg     = 1'b0;
      prs_stopped = 1'b0;
      prs_mag     = '0;
      prs_over    = 1'b0;
   endfunction

   function automatic void drop_arg();
      prs_sep_set = 1'b0;
      prs_sep     = 8'h00;
      drop_token();
   endfunction

   // any error reports once, then the parser stays silent
   function automatic parse_out_type raise_fault(logic [1:0] code);
      drop_arg();
      prs_halted = 1'b1;
      return parse_out_type'{num: '0, status: code};
   endfunction

   // magnitude saturates at 2^31; anything beyond marks the token over range
   function automatic void accumulate(logic [7:0] b);
      mag_type d;
      d = mag_type'(b - CHAR_ZERO);
      if (prs_mag > (MAG_LIMIT - d) / 10) begin
         prs_mag  = MAG_LIMIT;
         prs_over = 1'b1;
      end else begin
         prs_mag = prs_mag * 10 + d;
      end
   endfunction

   // 2^31 is legal only as a negative value
   function automatic parse_out_type close_token();
      parse_out_type r;
      if (prs_over || (!prs_neg && prs_mag >= MAG_LIMIT))
         return raise_fault(STATUS_RANGE);
      r.num    = prs_neg ? number_type'('0 - prs_mag) : number_type'(prs_mag);
      r.status = STATUS_OK;
      drop_token();
      return r;
   endfunction

   // applies one byte; returns 1 when the byte yields a value or an error
   function automatic bit parse_byte(input logic [7:0] b, input logic is_last,
                                     output parse_out_type r);
      bit got;
      got = 1'b0;
      r   = '0;
      if (prs_halted)
         return 1'b0;
      if (is_sep(b)) begin
         if (prs_sep_set && prs_sep != b) begin
            r = raise_fault(STATUS_MIXED_SEP);
            return 1'b1;
         end
         prs_sep_set = 1'b1;
         prs_sep     = b;
         if (prs_in_tok) begin
            r   = close_token();
            got = 1'b1;
         end
      end else if (is_digit(b) || b == CHAR_PLUS || b == CHAR_MINUS) begin
         if (!prs_in_tok) begin
            prs_in_tok  = 1'b1;
            prs_neg     = (b == CHAR_MINUS);
            prs_stopped = 1'b0;
            prs_mag     = '0;
            prs_over    = 1'b0;
            if (is_digit(b))
               accumulate(b);
         end else if (!prs_stopped) begin
            // first non-digit ends the value; the rest of the token is ignored
            if (is_digit(b))
               accumulate(b);
            else
               prs_stopped = 1'b1;
         end
         if (is_last) begin
            r   = close_token();
            got = 1'b1;
         end
      end else begin
         r = raise_fault(STATUS_BAD_BYTE);
         return 1'b1;
      end
      // argument end forgets the separator kind
      if (is_last && !prs_halted)
         drop_arg();
      return got;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // one transaction: random idle, hold until accepted, then book the outcome
   task automatic send_byte(input logic [7:0] b, input logic is_last, input chk_type chk,
                            input number_type want_num, input logic [1:0] want_st);
      int            gap;
      bit            got;
      parse_out_type r;
      gap = tx_burst ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 31) == 0)
         tx_burst = !tx_burst;
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push          <= 1'b1;
      req_text_byte <= b;
      req_arg_end   <= is_last;
      do @(posedge clock); while (full);
      got = parse_byte(b, is_last, r);
      case (chk)
         CHK_RESULT: pending_values.push_back(parse_out_type'{num: want_num,
                                                               status: want_st});
         default:    if (got) pending_values.push_back(r);
      endcase
      items_sent++;
   endtask

   task automatic run_rows(grp_type g);
      foreach (stim_rows[i])
         if (stim_rows[i].grp == g)
            send_byte(stim_rows[i].text, stim_rows[i].is_last, stim_rows[i].chk,
                      stim_rows[i].num, stim_rows[i].status);
   endtask

   // one argument; its last byte carries the argument-end flag
   task automatic send_text(input logic [7:0] text[$]);
      foreach (text[i])
         send_byte(text[i], i == text.size() - 1, CHK_PREDICT, '0, STATUS_OK);
   endtask

   // sender holds off until the block owes nothing
   task automatic hold_until_drained();
      push <= 1'b0;
      do @(posedge clock); while (pending_values.size() != 0);
   endtask

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 7))
         0:       return CHAR_COMMA;
         1:       return CHAR_SEMI;
         2:       return CHAR_SPACE;
         3:       return CHAR_TAB;
         4:       return CHAR_LF;
         5:       return CHAR_VT;
         6:       return CHAR_FF;
         default: return CHAR_CR;
      endcase
   endfunction

   function automatic logic [7:0] pick_sign();
      return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
   endfunction

   function automatic logic [7:0] pick_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // list of in-range tokens with one separator kind, some with sign,
   // leading zeros, trailing junk after the digits, or only a sign
   task automatic send_wellformed_arg();
      logic [7:0]      text[$];
      logic [7:0]      digs[$];
      logic [7:0]      sep;
      logic [7:0]      sgn;
      longint unsigned lim;
      longint unsigned v;
      int              ntok;
      sep  = pick_separator();
      ntok = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0)
         text.push_back(sep);
      for (int t = 0; t < ntok; t++) begin
         if (t != 0)
            repeat ($urandom_range(1, 2)) text.push_back(sep);
         if ($urandom_range(0, 9) == 0) begin
            // sign only, maybe followed by a second sign
            text.push_back(pick_sign());
            if ($urandom_range(0, 1))
               text.push_back(pick_sign());
         end else begin
            case ($urandom_range(0, 3))
               0:       sgn = CHAR_PLUS;
               1:       sgn = CHAR_MINUS;
               default: sgn = 8'h00;
            endcase
            if (sgn != 8'h00)
               text.push_back(sgn);
            lim = (sgn == CHAR_MINUS) ? 64'd2147483648 : 64'd2147483647;
            case ($urandom_range(0, 3))
               0: v = $urandom_range(0, 99);
               1: begin
                  v = $urandom;
                  v = v % (lim + 1);
               end
               2:       v = lim - $urandom_range(0, 3);
               default: v = $urandom_range(0, 99999);
            endcase
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 4)) text.push_back(CHAR_ZERO);
            digs = {};
            do begin
               digs.push_front(CHAR_ZERO + 8'(v % 10));
               v = v / 10;
            end while (v != 0);
            text = {text, digs};
            if ($urandom_range(0, 3) == 0) begin
               text.push_back(pick_sign());
               repeat ($urandom_range(0, 2))
                  text.push_back($urandom_range(0, 1) ? pick_digit() : pick_sign());
            end
         end
      end
      if (text.size() == 0 || $urandom_range(0, 1))
         text.push_back(sep);
      send_text(text);
   endtask

   // random mix of digits, signs and one separator kind; digit runs stay
   // short enough that no token can leave the value range
   task automatic send_noise_arg();
      logic [7:0] text[$];
      logic [7:0] sep;
      int         len;
      int         run;
      sep = pick_separator();
      len = $urandom_range(1, 12);
      run = 0;
      repeat (len) begin
         case ($urandom_range(0, 5))
            0: begin
               text.push_back(sep);
               run = 0;
            end
            1: begin
               text.push_back(pick_sign());
               run = 0;
            end
            default: begin
               if (run == 9) begin
                  text.push_back(sep);
                  run = 0;
               end else begin
                  text.push_back(pick_digit());
                  run++;
               end
            end
         endcase
      end
      send_text(text);
   endtask

   // ---------------------------------------------------------------------
   // response side: random stalls, each popped transaction checked in order
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      int            draw;
      parse_out_type want;
      if (reset) begin
         pop     <= 1'b0;
         rx_wait <= 0;
      end else if (pop && !empty) begin
         if (pending_values.size() == 0) begin
            $error("unexpected result: rsp_number %0d rsp_status %0d",
                   rsp_number, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_values.pop_front();
            if (rsp_number !== want.num) begin
               $error("rsp_number: expected %0d, got %0d", $signed(want.num), rsp_number);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
         draw = rx_burst ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 31) == 0)
            rx_burst <= !rx_burst;
         if (draw != 0) begin
            pop     <= 1'b0;
            rx_wait <= draw;
         end
      end else if (!pop) begin
         if (rx_wait <= 1)
            pop <= 1'b1;
         else
            rx_wait <= rx_wait - 1;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_rows(GRP_MAIN);
      hold_until_drained();

      // random arguments, mostly well-formed; every one ends on an argument
      // boundary so the error group below starts from a clean state
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0)
            send_noise_arg();
         else
            send_wellformed_arg();
         if ($urandom_range(0, 15) == 0)
            hold_until_drained();
      end

      // one error kind per run, since only reset leaves the halted state
      case ($urandom_range(0, 2))
         0:       run_rows(GRP_BAD);
         1:       run_rows(GRP_MIX);
         default: run_rows(GRP_RANGE);
      endcase

      // after the error any byte at all must be dropped silently
      repeat (20)
         send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), CHK_PREDICT,
                   '0, STATUS_OK);
      push <= 1'b0;

      while (pending_values.size() != 0) @(posedge clock);
      // leave room for stray results
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && pending_values.size() == 0)
         $display("** decimal_int_list_parser_core: PASSED **");
      else
         $display("** decimal_int_list_parser_core: FAILED **");
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("** decimal_int_list_parser_core: FAILED **");
      $finish;
   end

endmodule
